// ===== rtl/ttce_pkg.sv =====
package ttce_pkg;

    // Screen geometry and tab stop
    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;
    localparam int TAB_SPACES    = 4;

    localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CNT_W      = $clog2(TAB_SPACES + 1);
    localparam int ROW_W      = 5;
    localparam int COL_W      = 7;
    localparam int IDX_W      = 11;
    localparam int CELL_W     = 16;

    // Character codes
    localparam logic [7:0] CODE_BACKSPACE = 8'd8;
    localparam logic [7:0] CODE_TAB       = 8'd9;
    localparam logic [7:0] CODE_NEWLINE   = 8'd10;
    localparam logic [7:0] CODE_SPACE     = 8'h20;

    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0220;
    localparam logic [7:0]        RESET_COLOR = 8'd2;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_READ  = 1'b1
    } t_func;

    // Datapath operations of one control word
    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_PUT,
        MEM_READ,
        MEM_COPY,
        MEM_FLUSH,
        MEM_CLEAR,
        MEM_INIT
    } t_mem_op;

    typedef enum logic [1:0] {
        CUR_NONE,
        CUR_ADV,
        CUR_NL,
        CUR_BACK
    } t_cur_op;

    typedef enum logic [1:0] {
        PTR_NONE,
        PTR_ZERO,
        PTR_INC
    } t_ptr_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_WRAP_BOTTOM,
        C_BOTTOM,
        C_COL0,
        C_COPY_END,
        C_CLEAR_END,
        C_CNT_ZERO
    } t_cond;

    typedef logic [4:0] t_upc;

    typedef struct packed {
        t_mem_op mem;
        t_cur_op cur;
        t_ptr_op ptr;
        logic    cnt_dec;
        logic    fin;
        t_cond   cond;
        logic    neg;
        t_upc    target;
    } t_uword;

    // Status fed back from the datapath to the sequencer
    typedef struct packed {
        logic wrap_bottom;
        logic bottom;
        logic col0;
        logic copy_end;
        logic clear_end;
        logic cnt_zero;
    } t_flags;

    // Microprogram addresses
    localparam t_upc UPC_IDLE      = 5'd0;
    localparam t_upc UPC_PUT       = 5'd1;
    localparam t_upc UPC_PUT_CHK   = 5'd2;
    localparam t_upc UPC_FIN       = 5'd3;
    localparam t_upc UPC_NL        = 5'd4;
    localparam t_upc UPC_SCR       = 5'd5;
    localparam t_upc UPC_SCR_COPY  = 5'd6;
    localparam t_upc UPC_SCR_FLUSH = 5'd7;
    localparam t_upc UPC_SCR_CLEAR = 5'd8;
    localparam t_upc UPC_SCR_TAB   = 5'd9;
    localparam t_upc UPC_SCR_DONE  = 5'd10;
    localparam t_upc UPC_BS        = 5'd11;
    localparam t_upc UPC_BS_BACK   = 5'd12;
    localparam t_upc UPC_BS_PUT    = 5'd13;
    localparam t_upc UPC_READ      = 5'd14;
    localparam t_upc UPC_INIT      = 5'd15;
    localparam t_upc UPC_INIT_DONE = 5'd16;

    function automatic t_uword uw(
        input t_mem_op m,
        input t_cur_op c,
        input t_ptr_op p,
        input logic    dec,
        input logic    fin,
        input t_cond   cd,
        input logic    neg,
        input t_upc    tgt
    );
        t_uword w;
        w.mem     = m;
        w.cur     = c;
        w.ptr     = p;
        w.cnt_dec = dec;
        w.fin     = fin;
        w.cond    = cd;
        w.neg     = neg;
        w.target  = tgt;
        return w;
    endfunction

    // Control store
    function automatic t_uword ucode(input t_upc a);
        t_uword w;
        unique case (a)
            // put one cell at the cursor, advance; scroll when wrapping off the bottom
            UPC_PUT:       w = uw(MEM_PUT, CUR_ADV, PTR_NONE, 1'b1, 1'b0,
                                  C_WRAP_BOTTOM, 1'b0, UPC_SCR);
            UPC_PUT_CHK:   w = uw(MEM_NONE, CUR_NONE, PTR_NONE, 1'b0, 1'b0,
                                  C_CNT_ZERO, 1'b1, UPC_PUT);
            UPC_FIN:       w = uw(MEM_NONE, CUR_NONE, PTR_NONE, 1'b0, 1'b1,
                                  C_ALWAYS, 1'b0, UPC_IDLE);
            UPC_NL:        w = uw(MEM_NONE, CUR_NL, PTR_NONE, 1'b0, 1'b0,
                                  C_BOTTOM, 1'b1, UPC_FIN);
            // scroll: copy rows up, then clear the last row
            UPC_SCR:       w = uw(MEM_NONE, CUR_NONE, PTR_ZERO, 1'b0, 1'b0,
                                  C_NEVER, 1'b0, UPC_IDLE);
            UPC_SCR_COPY:  w = uw(MEM_COPY, CUR_NONE, PTR_INC, 1'b0, 1'b0,
                                  C_COPY_END, 1'b1, UPC_SCR_COPY);
            UPC_SCR_FLUSH: w = uw(MEM_FLUSH, CUR_NONE, PTR_NONE, 1'b0, 1'b0,
                                  C_NEVER, 1'b0, UPC_IDLE);
            UPC_SCR_CLEAR: w = uw(MEM_CLEAR, CUR_NONE, PTR_INC, 1'b0, 1'b0,
                                  C_CLEAR_END, 1'b1, UPC_SCR_CLEAR);
            UPC_SCR_TAB:   w = uw(MEM_NONE, CUR_NONE, PTR_NONE, 1'b0, 1'b0,
                                  C_CNT_ZERO, 1'b1, UPC_PUT);
            UPC_SCR_DONE:  w = uw(MEM_NONE, CUR_NONE, PTR_NONE, 1'b0, 1'b0,
                                  C_ALWAYS, 1'b0, UPC_FIN);
            // backspace
            UPC_BS:        w = uw(MEM_NONE, CUR_NONE, PTR_NONE, 1'b0, 1'b0,
                                  C_COL0, 1'b0, UPC_FIN);
            UPC_BS_BACK:   w = uw(MEM_NONE, CUR_BACK, PTR_NONE, 1'b0, 1'b0,
                                  C_NEVER, 1'b0, UPC_IDLE);
            UPC_BS_PUT:    w = uw(MEM_PUT, CUR_NONE, PTR_NONE, 1'b0, 1'b0,
                                  C_ALWAYS, 1'b0, UPC_FIN);
            UPC_READ:      w = uw(MEM_READ, CUR_NONE, PTR_NONE, 1'b0, 1'b0,
                                  C_ALWAYS, 1'b0, UPC_FIN);
            // power-up fill of the screen store
            UPC_INIT:      w = uw(MEM_INIT, CUR_NONE, PTR_INC, 1'b0, 1'b0,
                                  C_CLEAR_END, 1'b1, UPC_INIT);
            UPC_INIT_DONE: w = uw(MEM_NONE, CUR_NONE, PTR_NONE, 1'b0, 1'b0,
                                  C_ALWAYS, 1'b0, UPC_IDLE);
            default:       w = uw(MEM_NONE, CUR_NONE, PTR_NONE, 1'b0, 1'b0,
                                  C_NEVER, 1'b0, UPC_IDLE);
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/ttce_useq.sv =====
// Micro-sequencer: step counter, control store lookup, conditional jumps
module ttce_useq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ttce_pkg::t_upc    i_entry,
    input  logic              i_stall,
    input  ttce_pkg::t_flags  i_flags,
    output ttce_pkg::t_uword  o_uword,
    output logic              o_idle
);

    ttce_pkg::t_upc   r_upc;
    ttce_pkg::t_upc   n_upc;
    ttce_pkg::t_uword w_uw;
    logic             w_cond;
    logic             w_take;

    assign w_uw    = ttce_pkg::ucode(r_upc);
    assign o_uword = w_uw;
    assign o_idle  = (r_upc == ttce_pkg::UPC_IDLE);

    // Condition select
    always_comb begin
        unique case (w_uw.cond)
            ttce_pkg::C_NEVER:       w_cond = 1'b0;
            ttce_pkg::C_ALWAYS:      w_cond = 1'b1;
            ttce_pkg::C_WRAP_BOTTOM: w_cond = i_flags.wrap_bottom;
            ttce_pkg::C_BOTTOM:      w_cond = i_flags.bottom;
            ttce_pkg::C_COL0:        w_cond = i_flags.col0;
            ttce_pkg::C_COPY_END:    w_cond = i_flags.copy_end;
            ttce_pkg::C_CLEAR_END:   w_cond = i_flags.clear_end;
            ttce_pkg::C_CNT_ZERO:    w_cond = i_flags.cnt_zero;
        endcase
    end

    assign w_take = (w_uw.cond != ttce_pkg::C_NEVER) && (w_cond ^ w_uw.neg);

    // Next step
    always_comb begin
        if (o_idle) begin
            n_upc = i_start ? i_entry : r_upc;
        end else if (w_uw.fin && i_stall) begin
            n_upc = r_upc;
        end else if (w_take) begin
            n_upc = w_uw.target;
        end else begin
            n_upc = r_upc + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= ttce_pkg::UPC_INIT;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

// ===== rtl/text_terminal_cursor_engine_core.sv =====
// Channel   Dir  Handshake                  Payload
// s (item)  in   i_s_tvalid / o_s_tready    tdata: char_code, cell_index; tuser: func
// m (result)out  o_m_tvalid / i_m_tready    tdata: cell_data, cursor_row, cursor_column
// cfg       in   i_cfg_we                   i_cfg_wdata: text_color
//
// Items are taken only at the idle step, so a new item waits until the last
// one is through. A scroll moves one cell per cycle through the single
// write port of the screen store. After reset a fill pass holds input off;
// a waiting result stalls only the final step of the next item.
module text_terminal_cursor_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [7:0] char_code, [18:8] cell_index, zero fill
    input  logic [0:0]  i_s_tuser,   // [0] func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [15:0] cell_data, [20:16] cursor_row,
                                     // [27:21] cursor_column, zero fill
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata
);

    localparam int AW = ttce_pkg::ADDR_W;
    localparam int CW = ttce_pkg::CNT_W;
    localparam logic [ttce_pkg::COL_W-1:0] COL_LAST =
        ttce_pkg::COL_W'(ttce_pkg::SCREEN_WIDTH - 1);
    localparam logic [ttce_pkg::ROW_W-1:0] ROW_LAST =
        ttce_pkg::ROW_W'(ttce_pkg::SCREEN_HEIGHT - 1);
    localparam logic [AW-1:0] PTR_COPY_END =
        AW'(ttce_pkg::CELL_COUNT - ttce_pkg::SCREEN_WIDTH - 1);
    localparam logic [AW-1:0] PTR_CELL_END = AW'(ttce_pkg::CELL_COUNT - 1);

    ttce_pkg::t_uword w_uw;
    ttce_pkg::t_flags w_flags;
    ttce_pkg::t_upc   w_entry;
    logic             w_idle;
    logic             w_accept;
    logic             w_stall;
    logic             w_out_load;

    logic [7:0]                    w_code;
    logic [ttce_pkg::IDX_W-1:0]    w_idx;
    ttce_pkg::t_func               w_func;

    logic [7:0]                    r_color;
    ttce_pkg::t_func               r_func;
    logic [7:0]                    r_char;
    logic [ttce_pkg::IDX_W-1:0]    r_idx;
    logic                          r_in_range;
    logic [CW-1:0]                 r_cnt;
    logic [CW-1:0]                 n_cnt;
    logic [CW-1:0]                 w_cnt_load;
    logic [7:0]                    w_char_load;
    logic [ttce_pkg::ROW_W-1:0]    r_row;
    logic [ttce_pkg::ROW_W-1:0]    n_row;
    logic [ttce_pkg::COL_W-1:0]    r_col;
    logic [ttce_pkg::COL_W-1:0]    n_col;
    logic [AW-1:0]                 r_ptr;
    logic [AW-1:0]                 n_ptr;
    logic [AW-1:0]                 w_cur_addr;

    logic [ttce_pkg::CELL_W-1:0]   r_screen [ttce_pkg::CELL_COUNT];
    logic [ttce_pkg::CELL_W-1:0]   r_rd;
    logic                          w_we;
    logic [AW-1:0]                 w_wa;
    logic [ttce_pkg::CELL_W-1:0]   w_wd;
    logic                          w_re;
    logic [AW-1:0]                 w_ra;

    logic                          r_out_valid;
    logic [ttce_pkg::CELL_W-1:0]   r_out_cell;
    logic [ttce_pkg::ROW_W-1:0]    r_out_row;
    logic [ttce_pkg::COL_W-1:0]    r_out_col;

    assign w_code = i_s_tdata[7:0];
    assign w_idx  = i_s_tdata[18:8];
    assign w_func = ttce_pkg::t_func'(i_s_tuser[0]);

    assign o_s_tready = w_idle;
    assign w_accept   = i_s_tvalid && w_idle;
    assign w_stall    = r_out_valid && !i_m_tready;
    assign w_out_load = w_uw.fin && !w_stall;

    ttce_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_entry (w_entry),
        .i_stall (w_stall),
        .i_flags (w_flags),
        .o_uword (w_uw),
        .o_idle  (w_idle)
    );

    // Entry point, tab count and stored character for a new item
    always_comb begin
        w_entry     = ttce_pkg::UPC_PUT;
        w_cnt_load  = CW'(1);
        w_char_load = w_code;
        if (w_func == ttce_pkg::FUNC_READ) begin
            w_entry = ttce_pkg::UPC_READ;
        end else begin
            case (w_code)
                ttce_pkg::CODE_NEWLINE: begin
                    w_entry    = ttce_pkg::UPC_NL;
                    w_cnt_load = '0;
                end
                ttce_pkg::CODE_TAB: begin
                    w_cnt_load  = CW'(ttce_pkg::TAB_SPACES);
                    w_char_load = ttce_pkg::CODE_SPACE;
                end
                ttce_pkg::CODE_BACKSPACE: begin
                    w_entry     = ttce_pkg::UPC_BS;
                    w_cnt_load  = '0;
                    w_char_load = ttce_pkg::CODE_SPACE;
                end
                default: ;
            endcase
        end
    end

    // Status for the sequencer
    assign w_flags.wrap_bottom = (r_col == COL_LAST) && (r_row == ROW_LAST);
    assign w_flags.bottom      = (r_row == ROW_LAST);
    assign w_flags.col0        = (r_col == '0);
    assign w_flags.copy_end    = (r_ptr == PTR_COPY_END);
    assign w_flags.clear_end   = (r_ptr == PTR_CELL_END);
    assign w_flags.cnt_zero    = (r_cnt == '0);

    // Linear address of the cursor cell
    assign w_cur_addr = AW'(AW'(r_row) * AW'(ttce_pkg::SCREEN_WIDTH) + AW'(r_col));

    // Cursor update
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        unique case (w_uw.cur)
            ttce_pkg::CUR_ADV: begin
                if (r_col == COL_LAST) begin
                    n_col = '0;
                    n_row = (r_row == ROW_LAST) ? r_row : r_row + 1'b1;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            ttce_pkg::CUR_NL: begin
                n_col = '0;
                n_row = (r_row == ROW_LAST) ? r_row : r_row + 1'b1;
            end
            ttce_pkg::CUR_BACK: n_col = r_col - 1'b1;
            default: ;
        endcase
    end

    // Sweep pointer and tab count
    always_comb begin
        unique case (w_uw.ptr)
            ttce_pkg::PTR_ZERO: n_ptr = '0;
            ttce_pkg::PTR_INC:  n_ptr = r_ptr + 1'b1;
            default:            n_ptr = r_ptr;
        endcase
        if (w_accept) begin
            n_cnt = w_cnt_load;
        end else if (w_uw.cnt_dec) begin
            n_cnt = r_cnt - 1'b1;
        end else begin
            n_cnt = r_cnt;
        end
    end

    // Screen store port control
    always_comb begin
        w_we = 1'b0;
        w_wa = r_ptr;
        w_wd = '0;
        w_re = 1'b0;
        w_ra = r_ptr + AW'(ttce_pkg::SCREEN_WIDTH);
        unique case (w_uw.mem)
            ttce_pkg::MEM_PUT: begin
                w_we = 1'b1;
                w_wa = w_cur_addr;
                w_wd = {r_color, r_char};
            end
            ttce_pkg::MEM_READ: begin
                w_re = r_in_range;
                w_ra = r_idx[AW-1:0];
            end
            ttce_pkg::MEM_COPY: begin
                // each cell is written in the cycle after its read
                w_we = (r_ptr != '0);
                w_wa = r_ptr - 1'b1;
                w_wd = r_rd;
                w_re = 1'b1;
            end
            ttce_pkg::MEM_FLUSH: begin
                w_we = 1'b1;
                w_wa = r_ptr - 1'b1;
                w_wd = r_rd;
            end
            ttce_pkg::MEM_CLEAR: w_we = 1'b1;
            ttce_pkg::MEM_INIT: begin
                w_we = 1'b1;
                w_wd = ttce_pkg::RESET_CELL;
            end
            default: ;
        endcase
    end

    // Screen store
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_screen[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rd <= r_screen[w_ra];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color     <= ttce_pkg::RESET_COLOR;
            r_row       <= '0;
            r_col       <= '0;
            r_ptr       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_color <= i_cfg_wdata;
            end
            r_row <= n_row;
            r_col <= n_col;
            r_ptr <= n_ptr;
            r_cnt <= n_cnt;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item capture and result register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func     <= w_func;
            r_char     <= w_char_load;
            r_idx      <= w_idx;
            r_in_range <= (w_idx < ttce_pkg::IDX_W'(ttce_pkg::CELL_COUNT));
        end
        if (w_out_load) begin
            r_out_cell <= (r_func == ttce_pkg::FUNC_READ && r_in_range) ? r_rd : '0;
            r_out_row  <= r_row;
            r_out_col  <= r_col;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0, r_out_col, r_out_row, r_out_cell};

endmodule

// ===== bench/ttce_screen_checker.sv =====
module ttce_screen_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,   // [7:0] char_code, [18:8] cell_index, zero fill
    input  logic [0:0]  i_s_tuser,   // [0] func
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // [15:0] cell_data, [20:16] cursor_row,
                                     // [27:21] cursor_column, zero fill
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_checked,
    output int          o_scrolls
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ttce_pkg::CELL_W-1:0] cell_data;
        logic [ttce_pkg::ROW_W-1:0]  row;
        logic [ttce_pkg::COL_W-1:0]  col;
    } t_cursor_result;

    // Shadow copy of the terminal
    logic [ttce_pkg::CELL_W-1:0] screen_model [ttce_pkg::CELL_COUNT];
    logic [ttce_pkg::ROW_W-1:0]  cur_row;
    logic [ttce_pkg::COL_W-1:0]  cur_col;
    logic [7:0]                  attr;

    t_cursor_result cursor_results_q[$];

    function automatic void store_cell(input logic [7:0] code,
                                       input logic [ttce_pkg::COL_W-1:0] col,
                                       input logic [ttce_pkg::ROW_W-1:0] row);
        int unsigned pos;
        pos = row * ttce_pkg::SCREEN_WIDTH + col;
        if (pos < ttce_pkg::CELL_COUNT) begin
            screen_model[pos] = {attr, code};
        end
    endfunction

    // Rows move up by one; the freed bottom row goes to all zeros
    function automatic void scroll_screen();
        for (int i = 0; i < ttce_pkg::CELL_COUNT; i++) begin
            if (i < ttce_pkg::CELL_COUNT - ttce_pkg::SCREEN_WIDTH) begin
                screen_model[i] = screen_model[i + ttce_pkg::SCREEN_WIDTH];
            end else begin
                screen_model[i] = '0;
            end
        end
        cur_row = ttce_pkg::ROW_W'(ttce_pkg::SCREEN_HEIGHT - 1);
        o_scrolls++;
    endfunction

    function automatic void advance_row();
        cur_row = cur_row + 1'b1;
        if (cur_row >= ttce_pkg::SCREEN_HEIGHT) begin
            scroll_screen();
        end
    endfunction

    function automatic void place_char(input logic [7:0] code);
        store_cell(code, cur_col, cur_row);
        cur_col = cur_col + 1'b1;
        if (cur_col >= ttce_pkg::SCREEN_WIDTH) begin
            cur_col = '0;
            advance_row();
        end
    endfunction

    // Apply one input transaction, return the cell and cursor it should report
    function automatic t_cursor_result predict_terminal_step(
        input ttce_pkg::t_func f,
        input logic [7:0] code,
        input logic [ttce_pkg::IDX_W-1:0] idx
    );
        t_cursor_result r;
        r.cell_data = '0;
        if (f == ttce_pkg::FUNC_READ) begin
            if (idx < ttce_pkg::CELL_COUNT) begin
                r.cell_data = screen_model[idx];
            end
        end else if (code == ttce_pkg::CODE_NEWLINE) begin
            cur_col = '0;
            advance_row();
        end else if (code == ttce_pkg::CODE_TAB) begin
            for (int k = 0; k < ttce_pkg::TAB_SPACES; k++) begin
                place_char(ttce_pkg::CODE_SPACE);
            end
        end else if (code == ttce_pkg::CODE_BACKSPACE) begin
            // ignored at the left edge
            if (cur_col != 0) begin
                cur_col = cur_col - 1'b1;
                store_cell(ttce_pkg::CODE_SPACE, cur_col, cur_row);
            end
        end else begin
            place_char(code);
        end
        r.row = cur_row;
        r.col = cur_col;
        return r;
    endfunction

    function automatic void compare_result(input logic [31:0] d);
        t_cursor_result want;
        logic [ttce_pkg::CELL_W-1:0] got_cell;
        logic [ttce_pkg::ROW_W-1:0]  got_row;
        logic [ttce_pkg::COL_W-1:0]  got_col;
        got_cell = d[15:0];
        got_row  = d[20:16];
        got_col  = d[27:21];
        o_checked++;
        if (cursor_results_q.size() == 0) begin
            $error("result transaction with nothing expected: tdata 0x%08h", d);
            o_mismatches++;
            return;
        end
        want = cursor_results_q.pop_front();
        if (got_cell !== want.cell_data) begin
            $error("cell_data: expected 0x%04h, got 0x%04h", want.cell_data, got_cell);
            o_mismatches++;
        end
        if (got_row !== want.row) begin
            $error("cursor_row: expected %0d, got %0d", want.row, got_row);
            o_mismatches++;
        end
        if (got_col !== want.col) begin
            $error("cursor_column: expected %0d, got %0d", want.col, got_col);
            o_mismatches++;
        end
    endfunction

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_scrolls    = 0;
    end

    // Sample all channels on the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ttce_pkg::CELL_COUNT; i++) begin
                screen_model[i] = ttce_pkg::RESET_CELL;
            end
            cur_row = '0;
            cur_col = '0;
            attr    = ttce_pkg::RESET_COLOR;
            cursor_results_q.delete();
        end else begin
            if (i_cfg_we) begin
                attr = i_cfg_wdata;
            end
            if (i_s_tvalid && i_s_tready) begin
                cursor_results_q.push_back(
                    predict_terminal_step(ttce_pkg::t_func'(i_s_tuser[0]),
                                          i_s_tdata[7:0],
                                          i_s_tdata[18:8]));
            end
            if (i_m_tvalid && i_m_tready) begin
                compare_result(i_m_tdata);
            end
        end
        o_pending = cursor_results_q.size();
    end

endmodule

// ===== bench/tb_text_terminal_cursor_engine_core.sv =====
module tb_text_terminal_cursor_engine_core;

    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata   = '0;   // [7:0] char_code, [18:8] cell_index, zero fill
    logic [0:0]  i_s_tuser   = '0;   // [0] func
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [31:0] o_m_tdata;          // [15:0] cell_data, [20:16] cursor_row,
                                     // [27:21] cursor_column, zero fill
    logic        i_cfg_we    = 1'b0;
    logic [7:0]  i_cfg_wdata = '0;

    int mismatches;
    int pending;
    int checked;
    int scrolls;

    // no-stall stretch for both sides
    bit steady = 1'b0;

    int n_items      = 0;
    int n_reads      = 0;
    int n_newlines   = 0;
    int n_tabs       = 0;
    int n_backspaces = 0;
    int n_colors     = 0;

    text_terminal_cursor_engine_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    ttce_screen_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_scrolls    (scrolls)
    );

    always #5 i_clk = ~i_clk;

    // Result side backpressure
    always @(posedge i_clk) begin
        i_m_tready <= steady || ($urandom_range(99) >= 27);
    end

    // One input transaction; entered and left just after a rising edge
    task automatic send_item(input ttce_pkg::t_func f, input logic [7:0] code,
                             input logic [ttce_pkg::IDX_W-1:0] idx);
        while (!steady && $urandom_range(99) < 27) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= f;
        i_s_tdata  <= {5'b0, idx, code};
        do @(negedge i_clk); while (!o_s_tready);
        @(posedge i_clk);
        n_items++;
        if (f == ttce_pkg::FUNC_READ) begin
            n_reads++;
        end else if (code == ttce_pkg::CODE_NEWLINE) begin
            n_newlines++;
        end else if (code == ttce_pkg::CODE_TAB) begin
            n_tabs++;
        end else if (code == ttce_pkg::CODE_BACKSPACE) begin
            n_backspaces++;
        end
    endtask

    // Drain, let the block settle, then load a new attribute byte
    task automatic set_text_color(input logic [7:0] color);
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (10) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= color;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        n_colors++;
    endtask

    // Random traffic with a given mix of operations (percentages)
    task automatic run_mix(input int count, input int read_pct, input int nl_pct,
                           input int tab_pct, input int bs_pct);
        int pick;
        int sel;
        ttce_pkg::t_func f;
        logic [7:0] code;
        logic [ttce_pkg::IDX_W-1:0] idx;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            f    = ttce_pkg::FUNC_WRITE;
            code = 8'($urandom_range(255));
            idx  = ttce_pkg::IDX_W'($urandom_range(2047));
            if (pick < read_pct) begin
                f   = ttce_pkg::FUNC_READ;
                sel = $urandom_range(9);
                // mostly on screen, some around the bottom row and past the end
                if (sel < 7) begin
                    idx = ttce_pkg::IDX_W'($urandom_range(ttce_pkg::CELL_COUNT - 1));
                end else if (sel < 9) begin
                    idx = ttce_pkg::IDX_W'($urandom_range(
                              2047, ttce_pkg::CELL_COUNT - ttce_pkg::SCREEN_WIDTH));
                end
            end else if (pick < read_pct + nl_pct) begin
                code = ttce_pkg::CODE_NEWLINE;
            end else if (pick < read_pct + nl_pct + tab_pct) begin
                code = ttce_pkg::CODE_TAB;
            end else if (pick < read_pct + nl_pct + tab_pct + bs_pct) begin
                code = ttce_pkg::CODE_BACKSPACE;
            end
            send_item(f, code, idx);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset contents, edges of the fields, each control code
        send_item(ttce_pkg::FUNC_READ,  8'h00, 11'd0);
        send_item(ttce_pkg::FUNC_READ,  8'hFF, 11'd1999);
        send_item(ttce_pkg::FUNC_READ,  8'h00, 11'd2000);     // past the end reads zero
        send_item(ttce_pkg::FUNC_READ,  8'h55, 11'd2047);
        send_item(ttce_pkg::FUNC_WRITE, ttce_pkg::CODE_BACKSPACE, 11'd0); // left edge
        send_item(ttce_pkg::FUNC_WRITE, 8'h00, 11'd2047);     // nul is stored as a char
        send_item(ttce_pkg::FUNC_WRITE, 8'hFF, 11'd0);
        send_item(ttce_pkg::FUNC_WRITE, 8'h41, 11'h555);
        send_item(ttce_pkg::FUNC_READ,  8'h00, 11'd0);
        send_item(ttce_pkg::FUNC_READ,  8'h00, 11'd2);
        send_item(ttce_pkg::FUNC_WRITE, ttce_pkg::CODE_BACKSPACE, 11'h2AA);
        send_item(ttce_pkg::FUNC_READ,  ttce_pkg::CODE_NEWLINE, 11'd2); // code ignored
        send_item(ttce_pkg::FUNC_WRITE, ttce_pkg::CODE_TAB, 11'd0);
        send_item(ttce_pkg::FUNC_READ,  8'h00, 11'd5);
        send_item(ttce_pkg::FUNC_WRITE, ttce_pkg::CODE_NEWLINE, 11'd0);
        send_item(ttce_pkg::FUNC_WRITE, ttce_pkg::CODE_BACKSPACE, 11'd0);
        send_item(ttce_pkg::FUNC_WRITE, 8'h7E, 11'd80);
        send_item(ttce_pkg::FUNC_WRITE, ttce_pkg::CODE_NEWLINE, 11'd0);
        send_item(ttce_pkg::FUNC_WRITE, 8'h20, 11'd0);
        send_item(ttce_pkg::FUNC_READ,  8'h00, 11'd80);
        send_item(ttce_pkg::FUNC_READ,  8'h00, 11'd160);

        // Random phases, each under its own attribute byte
        set_text_color(8'hFF);
        run_mix(200, 25, 6, 5, 8);

        set_text_color(8'h00);
        steady = 1'b1;
        run_mix(200, 25, 6, 5, 8);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        steady = 1'b0;

        set_text_color(8'($urandom_range(255)));
        run_mix(200, 20, 30, 5, 5);     // newline heavy, many scrolls

        set_text_color(8'($urandom_range(255)));
        run_mix(200, 10, 0, 10, 3);     // long lines that wrap

        set_text_color(8'hA5);
        run_mix(200, 20, 4, 4, 35);     // backspace heavy

        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);

        $display("Covered %0d transactions: %0d reads, %0d newlines, %0d tabs, %0d backspaces",
                 n_items, n_reads, n_newlines, n_tabs, n_backspaces);
        $display("%0d attribute settings, %0d scrolls, %0d results compared",
                 n_colors + 1, scrolls, checked);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #100_000_000;
        $display("Watchdog expired with %0d results outstanding", pending);
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== text_terminal_cursor_engine_core.f =====
rtl/ttce_pkg.sv
rtl/ttce_useq.sv
rtl/text_terminal_cursor_engine_core.sv
bench/ttce_screen_checker.sv
bench/tb_text_terminal_cursor_engine_core.sv
